// ----- rtl/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
// Holds the cell command struct, opcode and status codes; no dependencies.
package ile_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int LEN_W         = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream payloads.
    localparam int OPC_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int FPOS_W = 6;

    localparam logic [OPC_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPC_W-1:0] OP_READ   = 3'd1;
    localparam logic [OPC_W-1:0] OP_WRITE  = 3'd2;
    localparam logic [OPC_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OPC_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OPC_W-1:0] OP_FIND   = 3'd5;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // What every cell does with its stored word in a cycle.
    localparam logic [1:0] CK_HOLD   = 2'd0;
    localparam logic [1:0] CK_WRITE  = 2'd1;
    localparam logic [1:0] CK_INSERT = 2'd2;
    localparam logic [1:0] CK_REMOVE = 2'd3;

    typedef logic [ELEMENT_WIDTH-1:0] t_elem;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] pos;
        t_elem            value;  // word to store, or the key of a find
        logic [LEN_W-1:0] count;  // list length before this request
        logic             load;   // capture the stored word into the probe
        logic             shift;  // move the probe one cell toward cell 0
    } t_cell_cmd;

    typedef struct packed {
        t_elem data;
        logic  match;
    } t_probe;

endpackage

// ----- rtl/ile_cell.sv -----
// One list cell: stores a single entry and a probe register of the scan chain.
// Depends on ile_pkg for the command and probe structs.
module ile_cell import ile_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_cmd        i_cmd,
    input  t_elem            i_left_value,
    input  t_elem            i_right_value,
    input  t_probe           i_right_probe,
    output t_elem            o_value,
    output t_probe           o_probe
);

    t_elem  r_value;
    t_elem  n_value;
    t_probe r_probe;
    t_probe n_probe;

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.kind)
            CK_WRITE: begin
                if (i_index == i_cmd.pos) n_value = i_cmd.value;
            end
            CK_INSERT: begin
                if (i_index > i_cmd.pos) begin
                    n_value = i_left_value;
                end else if (i_index == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end
            end
            CK_REMOVE: begin
                if (i_index >= i_cmd.pos) n_value = i_right_value;
            end
            default: n_value = r_value;
        endcase
    end

    // The probe takes the word as it was before this cycle's update, so a
    // remove can shift the list and start its scan in the same cycle.
    always_comb begin
        n_probe = r_probe;
        if (i_cmd.load) begin
            n_probe.data  = r_value;
            n_probe.match = (r_value == i_cmd.value) &&
                            ({1'b0, i_index} < i_cmd.count);
        end else if (i_cmd.shift) begin
            n_probe = i_right_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_probe <= n_probe;
    end

    assign o_value = r_value;
    assign o_probe = r_probe;

endmodule

// ----- rtl/indexed_list_engine.sv -----
// Indexed list engine on ile_cell and ile_pkg: append, write, insert and clear need no scan;
// read and remove at position p and find scan the list through the probe chain, which moves the
// stored words one cell per cycle toward cell 0 while the output is free; find stops at a match or
// at the list's end. One request is in flight at a time; a new request is taken only when no
// result waits or the waiting result transfers in that same cycle.
// Synchronous active-low reset clears the length, the controller and the result valid only.
module indexed_list_engine import ile_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] opcode, [9:3] position, [41:10] element_value, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [34:3] read_value, [40:35] found_position,
    // [47:41] list_length, [48] list_empty, [55:49] zero
    output logic [55:0] m_axis_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             r_state,  n_state;
    logic [LEN_W-1:0] r_count,  n_count;
    logic [IDX_W-1:0] r_scan,   n_scan;
    logic [IDX_W-1:0] r_pos,    n_pos;
    logic             r_find,   n_find;
    logic             r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_rd,     n_rd;
    logic [FPOS_W-1:0] r_fpos,   n_fpos;
    logic [LEN_W-1:0]  r_len,    n_len;

    logic [OPC_W-1:0] in_op;
    logic [POS_W-1:0] in_pos;
    t_elem            in_value;
    logic             in_null;
    logic             s_accept;
    logic             out_free;
    t_cell_cmd        cmd;

    t_elem  cell_value [CAPACITY];
    t_probe cell_probe [CAPACITY];

    assign in_op    = s_axis_tdata[2:0];
    assign in_pos   = s_axis_tdata[9:3];
    assign in_value = ELEMENT_WIDTH'(s_axis_tdata[41:10]);
    assign in_null  = (in_value == '0);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_pos       = r_pos;
        n_find      = r_find;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_rd        = r_rd;
        n_fpos      = r_fpos;
        n_len       = r_len;

        cmd.kind  = CK_HOLD;
        cmd.pos   = in_pos[IDX_W-1:0];
        cmd.value = in_value;
        cmd.count = r_count;
        cmd.load  = 1'b0;
        cmd.shift = 1'b0;

        if (s_accept) begin
            // Most requests answer at once; read, remove and find start a scan.
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_rd        = '0;
            n_fpos      = '0;
            n_scan      = '0;
            n_pos       = in_pos[IDX_W-1:0];
            n_find      = 1'b0;
            unique case (in_op)
                OP_APPEND: begin
                    if (in_null) begin
                        n_status = ST_NULL;
                    end else if (r_count >= LEN_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        cmd.kind = CK_WRITE;
                        cmd.pos  = r_count[IDX_W-1:0];
                        n_count  = r_count + 1'b1;
                    end
                end
                OP_READ: begin
                    if (LEN_W'(in_pos) >= r_count) begin
                        n_status = ST_BAD_POS;
                    end else begin
                        cmd.load    = 1'b1;
                        n_state     = ST_SCAN;
                        n_out_valid = r_out_valid && !m_axis_tready;
                    end
                end
                OP_WRITE: begin
                    if (in_null) begin
                        n_status = ST_NULL;
                    end else if (LEN_W'(in_pos) > r_count) begin
                        n_status = ST_BAD_POS;
                    end else if (LEN_W'(in_pos) == r_count) begin
                        if (r_count >= LEN_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.kind = CK_WRITE;
                            n_count  = r_count + 1'b1;
                        end
                    end else begin
                        cmd.kind = CK_WRITE;
                    end
                end
                OP_INSERT: begin
                    if (in_null) begin
                        n_status = ST_NULL;
                    end else if (LEN_W'(in_pos) > r_count) begin
                        n_status = ST_BAD_POS;
                    end else if (r_count >= LEN_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        cmd.kind = CK_INSERT;
                        n_count  = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (LEN_W'(in_pos) >= r_count) begin
                        n_status = ST_BAD_POS;
                    end else begin
                        cmd.kind    = CK_REMOVE;
                        cmd.load    = 1'b1;
                        n_count     = r_count - 1'b1;
                        n_state     = ST_SCAN;
                        n_out_valid = r_out_valid && !m_axis_tready;
                    end
                end
                OP_FIND: begin
                    if (in_null) begin
                        n_status = ST_NULL;
                    end else if (r_count == '0) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        cmd.load    = 1'b1;
                        n_find      = 1'b1;
                        n_state     = ST_SCAN;
                        n_out_valid = r_out_valid && !m_axis_tready;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
            n_len = n_count;
        end else if (r_state == ST_SCAN && out_free) begin
            // Cell 0 shows the entry at position r_scan.
            if (r_find) begin
                if (cell_probe[0].match) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_fpos      = FPOS_W'(r_scan);
                end else if (LEN_W'(r_scan) + 1'b1 == r_count) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_NOT_FOUND;
                end else begin
                    cmd.shift = 1'b1;
                    n_scan    = r_scan + 1'b1;
                end
            end else if (r_scan == r_pos) begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_rd        = DATA_W'(cell_probe[0].data);
            end else begin
                cmd.shift = 1'b1;
                n_scan    = r_scan + 1'b1;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_elem  left_value;
        t_elem  right_value;
        t_probe right_probe;

        if (g == 0) begin : g_first
            assign left_value = cell_value[g];
        end else begin : g_mid_l
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
            assign right_probe = '0;
        end else begin : g_mid_r
            assign right_value = cell_value[g+1];
            assign right_probe = cell_probe[g+1];
        end

        ile_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (IDX_W'(g)),
            .i_cmd         (cmd),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .i_right_probe (right_probe),
            .o_value       (cell_value[g]),
            .o_probe       (cell_probe[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_scan   <= n_scan;
        r_pos    <= n_pos;
        r_find   <= n_find;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
        r_len    <= n_len;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, (r_len == '0), r_len, r_fpos, r_rd, r_status};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !s_axis_tready)
        else $error("request taken during a scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !r_find) |-> (r_scan <= r_pos))
        else $error("position scan ran past its target");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_find) |-> (LEN_W'(r_scan) < r_count))
        else $error("find scan ran past the list length");

endmodule
